// ===== hdl/hsic_pkg.sv =====
// Shared types, constants and codes of the harmonic SNR insect classifier.
package hsic_pkg;

    localparam int MAX_BINS_DEF  = 1024;
    localparam int MAX_PEAKS_DEF = 64;

    localparam int KIND_W = 2;
    localparam int FREQ_W = 18;
    localparam int AMP_W  = 24;
    localparam int PEAK_W = 10;
    localparam int SP_W   = 2;
    localparam int SNR_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    // divider operand widths: ratio numerator is amp << 9, denominator two amps
    localparam int DIV_N = 34;
    localparam int DIV_D = 26;
    // harmonic position and thresholds (Q.4 and Q.5)
    localparam int H_W   = 20;
    // ratio sum and harmonic count (at most 16000 harmonics)
    localparam int RS_W  = 30;
    localparam int CNT_W = 15;

    localparam logic [KIND_W-1:0] KIND_BIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEAK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASS = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_GAP = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LO  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HI  = 2'd2;

    localparam logic [SP_W-1:0] SP_NONE   = 2'd0;
    localparam logic [SP_W-1:0] SP_HORNET = 2'd1;
    localparam logic [SP_W-1:0] SP_BEE    = 2'd2;
    localparam logic [SP_W-1:0] SP_FLY    = 2'd3;

    localparam logic [PEAK_W-1:0] GAP_RST = 10'd10;
    localparam logic [SNR_W-1:0]  LO_RST  = 16'd563;
    localparam logic [SNR_W-1:0]  HI_RST  = 16'd614;

    // frequencies in Q14.4
    localparam logic [FREQ_W-1:0] F_PEAK_LO = 18'd3200;
    localparam logic [FREQ_W-1:0] F_PEAK_HI = 18'd16000;
    localparam logic [H_W-1:0]    H_LO      = 20'd16000;
    localparam logic [H_W-1:0]    H_HI      = 20'd32000;
    localparam logic [H_W-1:0]    H_OFS     = 20'd32;
    localparam logic [FREQ_W-1:0] HORNET_LO = 18'd1760;
    localparam logic [FREQ_W-1:0] HORNET_HI = 18'd2160;
    localparam logic [FREQ_W-1:0] BEE_LO    = 18'd2368;
    localparam logic [FREQ_W-1:0] BEE_HI    = 18'd2912;
    localparam logic [FREQ_W-1:0] FLY_LO    = 18'd3040;
    localparam logic [FREQ_W-1:0] FLY_HI    = 18'd3360;
    localparam logic [SNR_W-1:0]  SNR_SAT   = 16'hFFFF;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
        logic [PEAK_W-1:0] peak;
    } t_in_req;

    typedef struct packed {
        logic [PEAK_W-1:0] gap;
        logic [SNR_W-1:0]  lo;
        logic [SNR_W-1:0]  hi;
    } t_cfg;

    typedef struct packed {
        logic [SP_W-1:0]   species;
        logic [FREQ_W-1:0] fund;
        logic [SNR_W-1:0]  snr;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] num;
        logic [DIV_D-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_N-1:0] quot;
        logic [DIV_D-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/harmonic_snr_insect_classifier.sv =====
// Top level of the harmonic SNR insect classifier: ports, config, result register.
//
//  channel   dir  handshake          payload
//  input     in   i_valid / o_stall  i_kind, i_bin_freq, i_bin_amp, i_peak_index
//  result    out  o_valid / i_stall  o_species, o_fundamental, o_harmonic_snr
//  config    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
//  Bin and peak loads are accepted back to back while idle.
//  A classify estimates f0 from the peaks, then runs each divide
//  through the one shared divider (f0, first harmonic, each ratio, mean),
//  and steps the bins with the three seek pointers for each harmonic.
//  o_stall is high for the whole classify; a finished result waits in the
//  sequencer until the result register is free. Reset is synchronous, no store
//  clearing pass: counts reset to zero.
module harmonic_snr_insect_classifier #(
    parameter int MAX_BINS  = hsic_pkg::MAX_BINS_DEF,
    parameter int MAX_PEAKS = hsic_pkg::MAX_PEAKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hsic_pkg::KIND_W-1:0]   i_kind,
    input  logic [hsic_pkg::FREQ_W-1:0]   i_bin_freq,
    input  logic [hsic_pkg::AMP_W-1:0]    i_bin_amp,
    input  logic [hsic_pkg::PEAK_W-1:0]   i_peak_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hsic_pkg::SP_W-1:0]     o_species,
    output logic [hsic_pkg::FREQ_W-1:0]   o_fundamental,
    output logic [hsic_pkg::SNR_W-1:0]    o_harmonic_snr,
    input  logic                          i_cfg_we,
    input  logic [hsic_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [hsic_pkg::CFG_W-1:0]    i_cfg_data
);
    import hsic_pkg::*;

    t_cfg     r_cfg;
    t_in_req  req;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid;
    logic     busy;
    logic     res_valid;
    logic     res_ready;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // input transfer
    assign req.valid = i_valid && !busy;
    assign req.kind  = i_kind;
    assign req.freq  = i_bin_freq;
    assign req.amp   = i_bin_amp;
    assign req.peak  = i_peak_index;
    assign o_stall   = busy;

    // result register frees when empty or being taken
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap   <= GAP_RST;
            r_cfg.lo    <= LO_RST;
            r_cfg.hi    <= HI_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAP: r_cfg.gap <= i_cfg_data[PEAK_W-1:0];
                    CFG_LO:  r_cfg.lo  <= i_cfg_data;
                    CFG_HI:  r_cfg.hi  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (res_valid && res_ready) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) r_out <= res;
    end

    hsic_ctrl #(
        .MAX_BINS  (MAX_BINS),
        .MAX_PEAKS (MAX_PEAKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cfg       (r_cfg),
        .i_res_ready (res_ready),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    hsic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_valid        = r_out_valid;
    assign o_species      = r_out.species;
    assign o_fundamental  = r_out.fund;
    assign o_harmonic_snr = r_out.snr;

endmodule

// ===== hdl/hsic_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module hsic_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsic_pkg::t_div_req i_req,
    output hsic_pkg::t_div_rsp o_rsp
);
    import hsic_pkg::*;

    localparam int CW = $clog2(DIV_N);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DIV_N-1:0] r_q, n_q;
    logic [DIV_D-1:0] r_r, n_r;
    logic [DIV_D-1:0] r_den, n_den;
    logic [DIV_D:0]   rem_sh;
    logic [DIV_D:0]   diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_den  = r_den;
        rem_sh = {r_r, r_q[DIV_N-1]};
        diff   = rem_sh - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.num;
            n_r    = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_r = diff[DIV_D-1:0];
                n_q = {r_q[DIV_N-2:0], 1'b1};
            end else begin
                n_r = rem_sh[DIV_D-1:0];
                n_q = {r_q[DIV_N-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_N - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_r   <= n_r;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

// ===== hdl/hsic_ctrl.sv =====
// Sequencer with spectrum and peak stores: f0 estimate, harmonic SNR, class.
module hsic_ctrl #(
    parameter int MAX_BINS  = hsic_pkg::MAX_BINS_DEF,
    parameter int MAX_PEAKS = hsic_pkg::MAX_PEAKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsic_pkg::t_in_req  i_req,
    input  hsic_pkg::t_cfg     i_cfg,
    input  logic               i_res_ready,
    output logic               o_busy,
    output logic               o_res_valid,
    output hsic_pkg::t_result  o_res,
    output hsic_pkg::t_div_req o_div_req,
    input  hsic_pkg::t_div_rsp i_div_rsp
);
    import hsic_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int PW = $clog2(MAX_PEAKS);
    localparam int SW = FREQ_W + PW + 2;
    localparam int EW = (AW + 1 > PEAK_W) ? AW + 1 : PEAK_W;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_INIT  = 19'h00002,
        S_A1    = 19'h00004,
        S_A2    = 19'h00008,
        S_LOOP  = 19'h00010,
        S_B1    = 19'h00020,
        S_B2    = 19'h00040,
        S_F0    = 19'h00080,
        S_F0W   = 19'h00100,
        S_H0W   = 19'h00200,
        S_HLOOP = 19'h00400,
        S_SK    = 19'h00800,
        S_SKC   = 19'h01000,
        S_AMP   = 19'h02000,
        S_RATIO = 19'h04000,
        S_RW    = 19'h08000,
        S_SNR   = 19'h10000,
        S_SW    = 19'h20000,
        S_FIN   = 19'h40000
    } t_state;

    t_state                   r_state, n_state;
    logic [AW:0]              r_bc, n_bc;
    logic [PW:0]              r_pc, n_pc;
    logic [PW:0]              r_i, n_i;
    logic [PEAK_W-1:0]        r_pa, n_pa;
    logic [PEAK_W-1:0]        r_pb, n_pb;
    logic [FREQ_W-1:0]        r_fa, n_fa;
    logic signed [SW-1:0]     r_sum, n_sum;
    logic [PW:0]              r_n, n_n;
    logic [FREQ_W-1:0]        r_f0, n_f0;
    logic [H_W-1:0]           r_h, n_h;
    logic [H_W-1:0]           r_thr, n_thr;
    logic [1:0]               r_sel, n_sel;
    logic [AW-1:0]            r_ptr [3];
    logic [AW-1:0]            n_ptr [3];
    logic [3:0]               r_ac, n_ac;
    logic [AMP_W-1:0]         r_top, n_top;
    logic [AMP_W-1:0]         r_mk, n_mk;
    logic [AMP_W-1:0]         r_ml, n_ml;
    logic [RS_W-1:0]          r_rsum, n_rsum;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    t_result                  r_res, n_res;

    logic [FREQ_W-1:0]        freq_mem [MAX_BINS];
    logic [AMP_W-1:0]         amp_mem  [MAX_BINS];
    logic [PEAK_W-1:0]        peak_mem [MAX_PEAKS];
    logic [FREQ_W-1:0]        r_freq_q;
    logic [AMP_W-1:0]         r_amp_q;
    logic [PEAK_W-1:0]        r_peak_q;
    logic [AW-1:0]            freq_ra, amp_ra;
    logic [PW-1:0]            peak_ra;
    logic                     bin_we, peak_we;

    logic [AW-1:0]            cur_ptr;
    logic [AW:0]              ptr_inc;
    logic [PW:0]              i_inc;
    logic [PEAK_W-1:0]        pdist;
    logic [H_W-1:0]           h2;
    logic [H_W-1:0]           f0x;
    logic [FREQ_W-1:0]        fb;
    logic [AMP_W:0]           noise2;
    logic [SNR_W-1:0]         ratio;
    logic [SNR_W-1:0]         snr;
    logic [SP_W-1:0]          sp;

    // clamp a peak index to the loaded bins
    function automatic logic [AW-1:0] f_edge(input logic [PEAK_W-1:0] idx,
                                             input logic [AW:0] bc);
        logic [EW-1:0] ix;
        logic [EW-1:0] bx;
        logic [AW:0]   bm;
        ix = EW'(idx);
        bx = EW'(bc);
        bm = bc - 1'b1;
        if (ix >= bx) return bm[AW-1:0];
        return ix[AW-1:0];
    endfunction

    // neighbor of a bin pointer, held at the edges; off 0 left, 1 center, 2 right
    function automatic logic [AW-1:0] f_nb(input logic [AW-1:0] p, input logic [1:0] off,
                                           input logic [AW:0] bc);
        logic [AW:0] pp;
        pp = {1'b0, p} + 1'b1;
        if (off == 2'd0) return (p == '0) ? p : p - 1'b1;
        if (off == 2'd2) return (pp < bc) ? pp[AW-1:0] : p;
        return p;
    endfunction

    assign cur_ptr = r_ptr[r_sel];
    assign ptr_inc = {1'b0, cur_ptr} + 1'b1;
    assign i_inc   = r_i + 1'b1;
    assign pdist   = (r_pa > r_pb) ? r_pa - r_pb : r_pb - r_pa;
    assign h2      = {r_h[H_W-2:0], 1'b0};
    assign f0x     = H_W'(r_f0);
    assign fb      = r_freq_q;
    assign noise2  = {1'b0, r_mk} + {1'b0, r_ml};
    assign ratio   = (i_div_rsp.quot > DIV_N'(SNR_SAT)) ? SNR_SAT : i_div_rsp.quot[SNR_W-1:0];
    assign snr     = i_div_rsp.quot[SNR_W-1:0];
    assign bin_we  = (r_state == S_IDLE) && i_req.valid && (i_req.kind == KIND_BIN)
                     && (r_bc < (AW+1)'(MAX_BINS));
    assign peak_we = (r_state == S_IDLE) && i_req.valid && (i_req.kind == KIND_PEAK)
                     && (r_pc < (PW+1)'(MAX_PEAKS));

    always_comb begin
        if ((r_f0 >= HORNET_LO) && (r_f0 <= HORNET_HI) && (snr < i_cfg.lo)) begin
            sp = SP_HORNET;
        end else if ((r_f0 >= BEE_LO) && (r_f0 <= BEE_HI) && (snr > i_cfg.hi)) begin
            sp = SP_BEE;
        end else if ((r_f0 >= FLY_LO) && (r_f0 <= FLY_HI) && (snr > i_cfg.hi)) begin
            sp = SP_FLY;
        end else begin
            sp = SP_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bc    = r_bc;
        n_pc    = r_pc;
        n_i     = r_i;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_fa    = r_fa;
        n_sum   = r_sum;
        n_n     = r_n;
        n_f0    = r_f0;
        n_h     = r_h;
        n_thr   = r_thr;
        n_sel   = r_sel;
        n_ptr   = r_ptr;
        n_ac    = r_ac;
        n_top   = r_top;
        n_mk    = r_mk;
        n_ml    = r_ml;
        n_rsum  = r_rsum;
        n_cnt   = r_cnt;
        n_res   = r_res;
        freq_ra = '0;
        amp_ra  = '0;
        peak_ra = '0;
        o_div_req.start = 1'b0;
        o_div_req.num   = '0;
        o_div_req.den   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (bin_we) n_bc = r_bc + 1'b1;
                    if (peak_we) n_pc = r_pc + 1'b1;
                    if (i_req.kind == KIND_CLASS) n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_i    = '0;
                n_sum  = '0;
                n_n    = '0;
                n_rsum = '0;
                n_cnt  = '0;
                for (int k = 0; k < 3; k++) n_ptr[k] = '0;
                n_res  = '0;
                if ((r_bc == '0) || (r_pc == '0)) n_state = S_FIN;
                else n_state = S_A1;
            end
            S_A1: begin
                n_pa    = r_peak_q;
                freq_ra = f_edge(r_peak_q, r_bc);
                n_state = S_A2;
            end
            S_A2: begin
                n_fa    = r_freq_q;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                peak_ra = i_inc[PW-1:0];
                if ((r_fa >= F_PEAK_HI) || (i_inc >= r_pc)) n_state = S_F0;
                else n_state = S_B1;
            end
            S_B1: begin
                n_pb    = r_peak_q;
                freq_ra = f_edge(r_peak_q, r_bc);
                n_state = S_B2;
            end
            S_B2: begin
                if ((r_fa > F_PEAK_LO) && (pdist > i_cfg.gap)) begin
                    n_sum = r_sum + $signed({{(SW-FREQ_W){1'b0}}, fb})
                                  - $signed({{(SW-FREQ_W){1'b0}}, r_fa});
                    n_n   = r_n + 1'b1;
                end
                n_pa    = r_pb;
                n_fa    = fb;
                n_i     = i_inc;
                n_state = S_LOOP;
            end
            S_F0: begin
                if ((r_n == '0) || (r_sum <= 0)) begin
                    n_state = S_FIN;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_N'($unsigned(r_sum));
                    o_div_req.den   = DIV_D'(r_n);
                    n_state = S_F0W;
                end
            end
            S_F0W: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.quot == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_f0      = i_div_rsp.quot[FREQ_W-1:0];
                        n_res.fund = i_div_rsp.quot[FREQ_W-1:0];
                        o_div_req.start = 1'b1;
                        o_div_req.num   = DIV_N'(H_LO);
                        o_div_req.den   = DIV_D'(i_div_rsp.quot[FREQ_W-1:0]);
                        n_state = S_H0W;
                    end
                end
            end
            S_H0W: begin
                // first multiple of f0 above 1000 Hz
                if (i_div_rsp.done) begin
                    n_h     = H_LO - H_W'(i_div_rsp.rem[FREQ_W-1:0]) + f0x;
                    n_state = S_HLOOP;
                end
            end
            S_HLOOP: begin
                if (r_h > H_HI) begin
                    n_state = S_SNR;
                end else begin
                    n_thr   = h2 - H_OFS;
                    n_sel   = 2'd0;
                    n_state = S_SK;
                end
            end
            S_SK: begin
                freq_ra = cur_ptr;
                n_state = S_SKC;
            end
            S_SKC: begin
                if ((ptr_inc < r_bc) && ({2'b0, r_freq_q, 1'b0} <= {1'b0, r_thr})) begin
                    n_ptr[r_sel] = ptr_inc[AW-1:0];
                    n_state = S_SK;
                end else begin
                    unique case (r_sel)
                        2'd0: begin
                            n_thr   = h2 - f0x - H_OFS;
                            n_sel   = 2'd1;
                            n_state = S_SK;
                        end
                        2'd1: begin
                            n_thr   = h2 + f0x - H_OFS;
                            n_sel   = 2'd2;
                            n_state = S_SK;
                        end
                        default: begin
                            n_ac    = '0;
                            n_state = S_AMP;
                        end
                    endcase
                end
            end
            S_AMP: begin
                // issue read r_ac, fold in data of read r_ac-1
                unique case (r_ac)
                    4'd0: amp_ra = f_nb(r_ptr[0], 2'd0, r_bc);
                    4'd1: amp_ra = f_nb(r_ptr[0], 2'd1, r_bc);
                    4'd2: amp_ra = f_nb(r_ptr[0], 2'd2, r_bc);
                    4'd3: amp_ra = f_nb(r_ptr[1], 2'd0, r_bc);
                    4'd4: amp_ra = f_nb(r_ptr[1], 2'd1, r_bc);
                    4'd5: amp_ra = f_nb(r_ptr[1], 2'd2, r_bc);
                    4'd6: amp_ra = f_nb(r_ptr[2], 2'd0, r_bc);
                    4'd7: amp_ra = f_nb(r_ptr[2], 2'd1, r_bc);
                    4'd8: amp_ra = f_nb(r_ptr[2], 2'd2, r_bc);
                    default: amp_ra = '0;
                endcase
                unique case (r_ac)
                    4'd1: n_top = r_amp_q;
                    4'd2, 4'd3: n_top = (r_amp_q > r_top) ? r_amp_q : r_top;
                    4'd4: n_mk = r_amp_q;
                    4'd5, 4'd6: n_mk = (r_amp_q < r_mk) ? r_amp_q : r_mk;
                    4'd7: n_ml = r_amp_q;
                    4'd8, 4'd9: n_ml = (r_amp_q < r_ml) ? r_amp_q : r_ml;
                    default: ;
                endcase
                if (r_ac == 4'd9) n_state = S_RATIO;
                else n_ac = r_ac + 1'b1;
            end
            S_RATIO: begin
                if (noise2 == '0) begin
                    n_rsum  = r_rsum + RS_W'(SNR_SAT);
                    n_cnt   = r_cnt + 1'b1;
                    n_h     = r_h + f0x;
                    n_state = S_HLOOP;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_N'({r_top, 9'd0});
                    o_div_req.den   = DIV_D'(noise2);
                    n_state = S_RW;
                end
            end
            S_RW: begin
                if (i_div_rsp.done) begin
                    n_rsum  = r_rsum + RS_W'(ratio);
                    n_cnt   = r_cnt + 1'b1;
                    n_h     = r_h + f0x;
                    n_state = S_HLOOP;
                end
            end
            S_SNR: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_N'(r_rsum);
                    o_div_req.den   = DIV_D'(r_cnt);
                    n_state = S_SW;
                end
            end
            S_SW: begin
                if (i_div_rsp.done) begin
                    n_res.snr     = snr;
                    n_res.species = sp;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_bc    = '0;
                    n_pc    = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            freq_mem[r_bc[AW-1:0]] <= i_req.freq;
            amp_mem[r_bc[AW-1:0]]  <= i_req.amp;
        end
        if (peak_we) peak_mem[r_pc[PW-1:0]] <= i_req.peak;
        r_freq_q <= freq_mem[freq_ra];
        r_amp_q  <= amp_mem[amp_ra];
        r_peak_q <= peak_mem[peak_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bc    <= '0;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_bc    <= n_bc;
            r_pc    <= n_pc;
        end
        r_i    <= n_i;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_fa   <= n_fa;
        r_sum  <= n_sum;
        r_n    <= n_n;
        r_f0   <= n_f0;
        r_h    <= n_h;
        r_thr  <= n_thr;
        r_sel  <= n_sel;
        r_ptr  <= n_ptr;
        r_ac   <= n_ac;
        r_top  <= n_top;
        r_mk   <= n_mk;
        r_ml   <= n_ml;
        r_rsum <= n_rsum;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while busy");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && i_res_ready) |=> (r_bc == '0 && r_pc == '0))
        else $error("stores not cleared after result transfer");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HLOOP) |-> ({1'b0, r_ptr[0]} < r_bc && {1'b0, r_ptr[1]} < r_bc
                                  && {1'b0, r_ptr[2]} < r_bc))
        else $error("bin pointer beyond loaded bins");
`endif

endmodule
